// File: rtl/core/allpass_bandpass_bandreject_filter_assert.svh
// Assertion macros for the allpass/bandpass/bandreject filter.
// Included by the modules that check their own sequencing.
`ifndef ALLPASS_BANDPASS_BANDREJECT_FILTER_ASSERT_SVH
`define ALLPASS_BANDPASS_BANDREJECT_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define ABF_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ABF_ASSERT_NOW(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ABF_ASSERT_IMPL(label, clk, rst_n, prop)
`define ABF_ASSERT_NOW(label, clk, prop)
`endif
`endif

// File: rtl/core/abf_pkg.sv
// Shared constants, types and helpers for the allpass/bandpass/bandreject filter.
// No dependencies.
package abf_pkg;
    localparam int SampleWidth  = 24;
    localparam int CoefFracBits = 22;
    localparam int CordicSteps  = 31;
    localparam int CordicIdxW   = 5;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam int FcWidth = 17;
    localparam int BwWidth = 17;
    localparam int FsWidth = 18;

    typedef enum logic [1:0] {
        REG_CENTER = 2'd0,
        REG_BANDWIDTH = 2'd1,
        REG_SAMPLE_RATE = 2'd2
    } t_reg_idx;

    function automatic logic signed [33:0] atan_turn(input logic [CordicIdxW-1:0] i);
        logic signed [33:0] v;
        v = 34'sd0;
        unique case (i)
            5'd0: v = 34'sd536870912;  5'd1: v = 34'sd316933406;
            5'd2: v = 34'sd167458907;  5'd3: v = 34'sd85004756;
            5'd4: v = 34'sd42667331;   5'd5: v = 34'sd21354465;
            5'd6: v = 34'sd10679838;   5'd7: v = 34'sd5340245;
            5'd8: v = 34'sd2670163;    5'd9: v = 34'sd1335087;
            5'd10: v = 34'sd667544;    5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;    5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;     5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;     5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;      5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;       5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;       5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;        5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;        5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;         5'd29: v = 34'sd1;
            5'd30: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction
endpackage

// File: rtl/core/abf_divider.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module abf_divider #(
    parameter int NW = 50,
    parameter int DW = 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy, r_done, n_done;
    logic [DW:0]   w_trial;

    always_comb begin
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[DW-1:0], r_q[NW-1]};
        if (i_start) begin
            n_q = i_num;
            n_rem = '0;
            n_cnt = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_q = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: rtl/core/abf_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q4.30 outputs.
// Depends on abf_pkg for the gain and arctangent table.
`include "allpass_bandpass_bandreject_filter_assert.svh"
module abf_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_phase,
    output logic               o_done,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);
    logic signed [33:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic [abf_pkg::CordicIdxW-1:0] r_i, n_i;
    logic r_busy, n_busy, r_done, n_done, r_flip, n_flip;
    logic [31:0] w_p;
    logic signed [33:0] w_dx, w_dy, w_a;

    always_comb begin
        n_x = r_x; n_y = r_y; n_z = r_z; n_i = r_i;
        n_busy = r_busy; n_done = 1'b0; n_flip = r_flip;
        w_p = i_phase ^ {(i_phase[31] ^ i_phase[30]), 31'd0};
        w_dx = r_y >>> r_i;
        w_dy = r_x >>> r_i;
        w_a = abf_pkg::atan_turn(r_i);
        if (i_start) begin
            n_flip = i_phase[31] ^ i_phase[30];
            n_x = abf_pkg::CordicGain;
            n_y = '0;
            n_z = {{2{w_p[31]}}, w_p};
            n_i = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                n_x = r_x - w_dx; n_y = r_y + w_dy; n_z = r_z - w_a;
            end else begin
                n_x = r_x + w_dx; n_y = r_y - w_dy; n_z = r_z + w_a;
            end
            n_i = r_i + 1'b1;
            if (r_i == abf_pkg::CordicIdxW'(abf_pkg::CordicSteps - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_i <= n_i;
        end
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_flip <= n_flip;
    end

    assign o_done = r_done;
    assign o_cos = r_flip ? -r_x : r_x;
    assign o_sin = r_flip ? -r_y : r_y;

    `ABF_ASSERT_IMPL(a_cordic_done_one, i_clk, i_rst_n, r_done |=> !r_done)
    `ABF_ASSERT_IMPL(a_cordic_no_restart, i_clk, i_rst_n, r_busy |-> !i_start)
    `ABF_ASSERT_IMPL(a_cordic_done_idle, i_clk, i_rst_n, r_done |-> !r_busy)
endmodule

// File: rtl/core/abf_mult.sv
// Registered signed multiplier shared by all filter products.
// No package dependencies.
module abf_mult #(
    parameter int AW = 34,
    parameter int BW = 34
) (
    input  logic                 i_clk,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);
    logic signed [AW+BW-1:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule

// File: rtl/core/allpass_bandpass_bandreject_filter.sv
// Second-order allpass with bandpass and bandreject outputs, fixed point.
// Per input word: two NW-bit divisions (NW = 54), a third only when sin + cos is nonzero,
// two CORDIC runs and eight multiply/output steps, on one shared divider, CORDIC and
// multiplier. A new word is accepted only in idle, after the output is taken; i_stall
// holds the output (o_valid) until it is released.
// Synchronous active-low reset restores registers 400/50/48000 and zero history.
`include "allpass_bandpass_bandreject_filter_assert.svh"
module allpass_bandpass_bandreject_filter #(
    parameter int SAMPLE_WIDTH   = abf_pkg::SampleWidth,
    parameter int COEF_FRAC_BITS = abf_pkg::CoefFracBits
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic o_valid,
    input  logic i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_bandpass_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_bandreject_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_allpass_out,
    input  logic i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [abf_pkg::FsWidth-1:0] i_cfg_data
);
    localparam int F = COEF_FRAC_BITS;
    localparam int CW = F + 2;
    localparam int W = SAMPLE_WIDTH;
    localparam int MW = 34;
    localparam int NW = (F + 32 > 50) ? F + 32 : 50;
    localparam int DW = 34;
    localparam logic signed [MW-1:0] One = MW'(1) <<< F;
    localparam logic signed [MW-1:0] G99 = MW'(((longint'(99) << F) + 50) / 100);
    localparam logic signed [MW-1:0] CHi = (One <<< 1) - 1;
    localparam logic signed [MW-1:0] CLo = -(One <<< 1);
    localparam logic signed [MW-1:0] WHi = (MW'(1) <<< (W - 1)) - 1;
    localparam logic signed [MW-1:0] WLo = -(MW'(1) <<< (W - 1));

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001, S_DIV1 = 14'b00000000000010,
        S_DIV2 = 14'b00000000000100, S_COR1 = 14'b00000000001000,
        S_COR2 = 14'b00000000010000, S_DIVC = 14'b00000000100000,
        S_K    = 14'b00000001000000, S_KW   = 14'b00000010000000,
        S_M1   = 14'b00000100000000, S_M2   = 14'b00001000000000,
        S_AP   = 14'b00010000000000, S_BR   = 14'b00100000000000,
        S_BRW  = 14'b01000000000000, S_OUT  = 14'b10000000000000
    } t_state;

    t_state r_st, n_st;
    logic [abf_pkg::FcWidth-1:0] r_fc;
    logic [abf_pkg::BwWidth-1:0] r_bw;
    logic [abf_pkg::FsWidth-1:0] r_fs;
    logic signed [W-1:0] r_x, r_x1, r_x2, r_y1, r_y2;
    logic signed [W-1:0] r_bp, r_br, r_ap;
    logic [31:0] r_p1, r_p2;
    logic signed [MW-1:0] r_d, r_c, r_k, r_t1;
    logic r_sub;

    logic div_start, div_done, cor_start, cor_done;
    logic [NW-1:0] div_num, div_quot;
    logic [DW-1:0] div_den;
    logic [31:0] cor_phase;
    logic signed [33:0] cor_cos, cor_sin;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;
    logic [DW-1:0] w_fs;

    abf_divider #(.NW(NW), .DW(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(div_den), .o_done(div_done), .o_quot(div_quot));
    abf_cordic u_cor (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start), .i_phase(cor_phase),
        .o_done(cor_done), .o_cos(cor_cos), .o_sin(cor_sin));
    abf_mult #(.AW(MW), .BW(MW)) u_mul (
        .i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    function automatic logic signed [MW-1:0] satc(input logic signed [2*MW-1:0] v,
                                                 input logic signed [MW-1:0] hi,
                                                 input logic signed [MW-1:0] lo);
        logic signed [MW-1:0] r;
        if (v > 68'(hi)) r = hi;
        else if (v < 68'(lo)) r = lo;
        else r = v[MW-1:0];
        return r;
    endfunction

    function automatic logic signed [2*MW-1:0] rndf(input logic signed [2*MW-1:0] v,
                                                   input int s);
        logic signed [2*MW-1:0] r;
        if (s == 0) r = v;
        else r = (v + (68'sd1 <<< (s - 1))) >>> s;
        return r;
    endfunction

    logic signed [MW-1:0] w_q, w_apr, w_cq;
    logic signed [2*MW-1:0] w_apsum, w_d;

    always_comb begin
        w_fs = (r_fs == '0) ? DW'(1) : DW'(r_fs);
        div_start = 1'b0;
        div_num = '0;
        div_den = w_fs;
        cor_start = 1'b0;
        cor_phase = '0;
        mul_a = '0;
        mul_b = '0;
        n_st = r_st;
        w_q = (div_quot > NW'(One <<< 1)) ? (One <<< 1) : MW'(div_quot);
        w_cq = satc(68'(r_sub ? -w_q : w_q), CHi, CLo);
        w_apsum = rndf(mul_p, F) + 68'(r_t1) + 68'(r_x2);
        w_apr = satc(w_apsum, WHi, WLo);
        w_d = rndf(68'(cor_cos), 30 - F);
        unique case (r_st)
            S_IDLE: if (i_valid) begin
                div_start = 1'b1;
                div_num = NW'(r_fc) << 32;
                n_st = S_DIV1;
            end
            S_DIV1: if (div_done) begin
                div_start = 1'b1;
                div_num = NW'(r_bw) << 31;
                n_st = S_DIV2;
            end
            S_DIV2: if (div_done) begin
                cor_start = 1'b1;
                cor_phase = r_p1;
                n_st = S_COR1;
            end
            S_COR1: if (cor_done) begin
                cor_start = 1'b1;
                cor_phase = r_p2;
                n_st = S_COR2;
            end
            S_COR2: if (cor_done) begin
                if (cor_sin + cor_cos != 0) begin
                    div_start = 1'b1;
                    div_num = NW'(((NW'(cor_sin - cor_cos < 0 ? cor_cos - cor_sin
                                        : cor_sin - cor_cos)) << F))
                              + (NW'(cor_sin + cor_cos < 0 ? -(cor_sin + cor_cos)
                                        : cor_sin + cor_cos) >> 1);
                    div_den = DW'(cor_sin + cor_cos < 0 ? -(cor_sin + cor_cos)
                                        : cor_sin + cor_cos);
                    n_st = S_DIVC;
                end else begin
                    n_st = S_K;
                end
            end
            S_DIVC: if (div_done) n_st = S_K;
            S_K: begin
                mul_a = r_d;
                mul_b = One - r_c;
                n_st = S_KW;
            end
            S_KW: begin
                mul_a = MW'(r_y2) - MW'(r_x);
                mul_b = r_c;
                n_st = S_M1;
            end
            S_M1: n_st = S_M2;
            S_M2: begin
                mul_a = MW'(r_x1) - MW'(r_y1);
                mul_b = r_k;
                n_st = S_AP;
            end
            S_AP: begin
                mul_a = G99;
                mul_b = MW'(w_apr);
                n_st = S_BR;
            end
            S_BR: n_st = S_BRW;
            S_BRW: n_st = S_OUT;
            S_OUT: if (!i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_fc <= abf_pkg::FcWidth'(400);
            r_bw <= abf_pkg::BwWidth'(50);
            r_fs <= abf_pkg::FsWidth'(48000);
            r_x1 <= '0; r_x2 <= '0; r_y1 <= '0; r_y2 <= '0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    abf_pkg::REG_CENTER: r_fc <= i_cfg_data[abf_pkg::FcWidth-1:0];
                    abf_pkg::REG_BANDWIDTH: r_bw <= i_cfg_data[abf_pkg::BwWidth-1:0];
                    abf_pkg::REG_SAMPLE_RATE: r_fs <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_st == S_AP) begin
                r_x2 <= r_x1; r_x1 <= r_x;
                r_y2 <= r_y1; r_y1 <= w_apr[W-1:0];
            end
        end
        if (r_st == S_IDLE && i_valid) r_x <= i_sample_in;
        if (r_st == S_DIV1 && div_done) r_p1 <= div_quot[31:0];
        if (r_st == S_DIV2 && div_done) r_p2 <= div_quot[31:0];
        if (r_st == S_COR1 && cor_done) r_d <= satc(-w_d, CHi, CLo);
        if (r_st == S_COR2 && cor_done) begin
            r_sub <= (cor_sin - cor_cos < 0) != (cor_sin + cor_cos < 0);
            if (cor_sin + cor_cos == 0)
                r_c <= (cor_sin - cor_cos > 0) ? CHi
                     : ((cor_sin - cor_cos < 0) ? CLo : '0);
        end
        if (r_st == S_DIVC && div_done) r_c <= w_cq;
        if (r_st == S_KW) r_k <= satc(rndf(mul_p, F), CHi, CLo);
        if (r_st == S_M1) r_t1 <= MW'(rndf(mul_p, F));
        if (r_st == S_AP) begin
            r_ap <= w_apr[W-1:0];
            r_bp <= W'(satc(rndf(68'(r_x) - 68'(w_apr), 1), WHi, WLo));
        end
        if (r_st == S_BR)
            r_br <= W'(satc(rndf((68'(r_x) <<< F) + mul_p, F + 1), WHi, WLo));
    end

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_bandpass_out = r_bp;
    assign o_bandreject_out = r_br;
    assign o_allpass_out = r_ap;

    `ABF_ASSERT_IMPL(a_onehot, i_clk, i_rst_n, $onehot(r_st))
    `ABF_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> o_valid)
    `ABF_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, o_valid |-> o_stall)
endmodule
